>>> design/cpa_pkg.sv
// Shared constants and a helper function for the CPA key ranking block.
// Depends on nothing; compile first.
package cpa_pkg;

  localparam int PT_W   = 6;
  localparam int LEAK_W = 12;
  localparam int KEY_W  = 6;
  localparam int CORR_W = 16;
  localparam int HYP_W  = 3;

  // DES S-box 1, indexed by {row, column}.
  localparam logic [3:0] SBOX1 [0:63] = '{
    4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
    4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
    4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
    4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
    4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
    4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
    4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
    4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13
  };

  // Hamming weight of S1(pt xor guess); the outer bits pick the row.
  function automatic logic [HYP_W-1:0] hyp(input logic [PT_W-1:0] pt,
                                           input logic [KEY_W-1:0] guess);
    logic [5:0] v;
    logic [3:0] s;
    v = pt ^ guess;
    s = SBOX1[{v[5], v[0], v[4:1]}];
    return HYP_W'(s[0]) + HYP_W'(s[1]) + HYP_W'(s[2]) + HYP_W'(s[3]);
  endfunction

endpackage

>>> design/cpa_if.sv
// Valid/ready channel interfaces for trace requests and ranking results.
// Depends on cpa_pkg for the field widths.
interface cpa_in_if import cpa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [PT_W-1:0]   plaintext;
  logic [LEAK_W-1:0] leakage;
  logic              last;
  modport source (output valid, plaintext, leakage, last, input ready);
  modport sink (input valid, plaintext, leakage, last, output ready);
endinterface

interface cpa_out_if import cpa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  key_guess;
  logic [CORR_W-1:0] corr_magnitude;
  logic [KEY_W-1:0]  best_key;
  logic [CORR_W-1:0] best_corr;
  logic              overflow;
  logic              last_result;
  modport source (output valid, key_guess, corr_magnitude, best_key, best_corr,
                  overflow, last_result, input ready);
  modport sink (input valid, key_guess, corr_magnitude, best_key, best_corr,
                overflow, last_result, output ready);
endinterface

>>> design/cpa_mul.sv
// Shared shift-and-add multiplier, one multiplier bit per cycle.
// Stand-alone; no package needed.
module cpa_mul #(
  parameter int W = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           busy,
  output logic           done,
  output logic [2*W-1:0] p
);

  logic [2*W-1:0] as;
  logic [W-1:0]   bs;

  // The loop ends as soon as the remaining multiplier bits are all zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        p    <= '0;
        as   <= (2*W)'(a);
        bs   <= b;
      end else if (busy) begin
        if (bs[0]) p <= p + as;
        as <= as << 1;
        bs <= bs >> 1;
        if ((bs >> 1) == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/cpa_key_rank_des_sbox.sv
// Top level of the CPA key ranking block for DES S-box 1.
// Depends on cpa_pkg, cpa_if (cpa_in_if, cpa_out_if) and cpa_mul.
//
//   channel  dir  contents                                      per request
//   in_ch    in   plaintext, leakage, last                      one trace
//   out_ch   out  key_guess, corr_magnitude, best_key,          one guess
//                 best_corr, overflow, last_result
//
// Traces load at one per cycle; in_ch.ready is high whenever the block is idle.
// A trace with last set starts a ranking pass of 64 guesses, during which
// in_ch.ready is low. Per guess the pass sweeps the n stored traces, then
// forms six products on the shared shift-add multiplier, runs a 16-bit root
// search and ranks; the last two products and the search are skipped when
// either variance is zero. The pass opens with two further products.
// A result waits in the output register until taken; the pass stalls meanwhile.
// Reset is synchronous and clears control state and sums; the trace memory
// is not cleared, since only entries below the trace count are ever read.
module cpa_key_rank_des_sbox import cpa_pkg::*; #(
  parameter int MAX_TRACES   = 256,
  parameter int LEAKAGE_BITS = 12
) (
  input logic      clk,
  input logic      rst,
  cpa_in_if.sink   in_ch,
  cpa_out_if.source out_ch
);

  // Widths follow from the trace capacity and the sample width.
  localparam int CW    = $clog2(MAX_TRACES + 1);
  localparam int AW    = $clog2(MAX_TRACES);
  localparam int LB    = LEAKAGE_BITS;
  localparam int SUMW  = LB + CW;
  localparam int SQW   = 2 * LB + CW;
  localparam int SHW   = CW + 3;
  localparam int SH2W  = CW + 5;
  localparam int SXHW  = LB + CW + 3;
  localparam int VXW   = SQW + CW;
  localparam int VHW   = SH2W + CW;
  localparam int SXYW  = SXHW + CW;
  localparam int MW    = (VXW > SXYW) ? VXW : SXYW;
  localparam int PW    = VXW + VHW;
  localparam int TW    = PW + 32;
  localparam int MEMW  = PT_W + LB;

  // Sequencer codes.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_VX_A   = 4'd1;
  localparam logic [3:0] S_VX_B   = 4'd2;
  localparam logic [3:0] S_SWEEP  = 4'd3;
  localparam logic [3:0] S_VH_A   = 4'd4;
  localparam logic [3:0] S_VH_B   = 4'd5;
  localparam logic [3:0] S_SXY_A  = 4'd6;
  localparam logic [3:0] S_SXY_B  = 4'd7;
  localparam logic [3:0] S_R_M    = 4'd8;
  localparam logic [3:0] S_P_M    = 4'd9;
  localparam logic [3:0] S_SEARCH = 4'd10;
  localparam logic [3:0] S_RANK   = 4'd11;
  localparam logic [3:0] S_EMIT   = 4'd12;

  logic [3:0] state;

  // Run state.
  logic [CW-1:0]   count;
  logic [SUMW-1:0] sum;
  logic [SQW-1:0]  sq;
  logic            dropped;

  // Trace memory: plaintext in the upper bits, leakage below.
  logic [MEMW-1:0] mem [0:MAX_TRACES-1];
  logic [MEMW-1:0] rd_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [LB-1:0]   x_in;

  // Per-guess sweep.
  logic [KEY_W-1:0] g;
  logic [CW-1:0]    idx;
  logic             rd_pending;
  logic [SHW-1:0]   sh;
  logic [SH2W-1:0]  sh2;
  logic [SXHW-1:0]  sxh;
  logic [HYP_W-1:0] h;
  logic [5:0]       hsq;
  logic [LB+2:0]    hx;

  // Correlation terms.
  logic [2*MW-1:0] t1;
  logic [VXW-1:0]  vx;
  logic [VHW-1:0]  vh;
  logic [SXYW-1:0] sxy;
  logic [TW-1:0]   rr;
  logic [TW-1:0]   acc_a;
  logic [TW-1:0]   acc_b;
  logic [TW-1:0]   q2p;
  logic [TW-1:0]   trial;
  logic [3:0]      bit_idx;
  logic [CORR_W-1:0] q;

  // Best tracking.
  logic [KEY_W-1:0]  best_key;
  logic [CORR_W-1:0] best_corr;

  // Multiplier port.
  logic          mul_start;
  logic          mul_busy;
  logic          mul_done;
  logic          mul_wait;
  logic          mul_state;
  logic [MW-1:0] mul_a;
  logic [MW-1:0] mul_b;
  logic [2*MW-1:0] mul_p;

  logic in_acc;
  logic out_acc;

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_ch.valid && out_ch.ready;
  assign x_in        = LB'(in_ch.leakage);
  assign wr_en       = in_acc && (count < CW'(MAX_TRACES));

  assign rd_en   = (state == S_SWEEP) && (idx < count);
  assign rd_addr = idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) mem[count[AW-1:0]] <= {in_ch.plaintext, x_in};
    if (rd_en) rd_data <= mem[rd_addr];
  end

  assign h   = hyp(rd_data[MEMW-1:LB], g);
  assign hsq = 6'(h) * 6'(h);
  assign hx  = (LB + 3)'(h) * (LB + 3)'(rd_data[LB-1:0]);

  assign trial = q2p + acc_b + acc_a;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_state = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      S_VX_A: begin
        mul_a = MW'(count);
        mul_b = MW'(sq);
      end
      S_VX_B: begin
        mul_a = MW'(sum);
        mul_b = MW'(sum);
      end
      S_VH_A: begin
        mul_a = MW'(count);
        mul_b = MW'(sh2);
      end
      S_VH_B: begin
        mul_a = MW'(sh);
        mul_b = MW'(sh);
      end
      S_SXY_A: begin
        mul_a = MW'(count);
        mul_b = MW'(sxh);
      end
      S_SXY_B: begin
        mul_a = MW'(sum);
        mul_b = MW'(sh);
      end
      S_R_M: begin
        mul_a = MW'(sxy);
        mul_b = MW'(sxy);
      end
      S_P_M: begin
        mul_a = MW'(vx);
        mul_b = MW'(vh);
      end
      default: mul_state = 1'b0;
    endcase
  end

  assign mul_start = mul_state && !mul_wait;

  cpa_mul #(.W(MW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      sum          <= '0;
      sq           <= '0;
      dropped      <= 1'b0;
      mul_wait     <= 1'b0;
      rd_pending   <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (mul_start) mul_wait <= 1'b1;
      if (mul_done) mul_wait <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (wr_en) begin
              count <= count + 1'b1;
              sum   <= sum + SUMW'(x_in);
              sq    <= sq + SQW'(x_in) * SQW'(x_in);
            end else begin
              dropped <= 1'b1;
            end
            if (in_ch.last) begin
              g         <= '0;
              best_key  <= '0;
              best_corr <= '0;
              state     <= S_VX_A;
            end
          end
        end
        S_VX_A: begin
          if (mul_done) begin
            t1    <= mul_p;
            state <= S_VX_B;
          end
        end
        S_VX_B: begin
          if (mul_done) begin
            vx    <= VXW'(t1 - mul_p);
            idx   <= '0;
            sh    <= '0;
            sh2   <= '0;
            sxh   <= '0;
            state <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          // One memory read per cycle; the read data is summed in the cycle after.
          rd_pending <= rd_en;
          if (rd_en) idx <= idx + 1'b1;
          if (rd_pending) begin
            sh  <= sh + SHW'(h);
            sh2 <= sh2 + SH2W'(hsq);
            sxh <= sxh + SXHW'(hx);
          end
          if (!rd_en && !rd_pending) state <= S_VH_A;
        end
        S_VH_A: begin
          if (mul_done) begin
            t1    <= mul_p;
            state <= S_VH_B;
          end
        end
        S_VH_B: begin
          if (mul_done) begin
            vh    <= VHW'(t1 - mul_p);
            state <= S_SXY_A;
          end
        end
        S_SXY_A: begin
          if (mul_done) begin
            t1    <= mul_p;
            state <= S_SXY_B;
          end
        end
        S_SXY_B: begin
          if (mul_done) begin
            sxy <= (t1 >= mul_p) ? SXYW'(t1 - mul_p) : SXYW'(mul_p - t1);
            q   <= '0;
            // A flat hypothesis or flat leakage has no defined correlation.
            if (vx == '0 || vh == '0) state <= S_RANK;
            else state <= S_R_M;
          end
        end
        S_R_M: begin
          if (mul_done) begin
            rr    <= TW'(mul_p) << 30;
            state <= S_P_M;
          end
        end
        S_P_M: begin
          if (mul_done) begin
            acc_a   <= TW'(mul_p) << 30;
            acc_b   <= '0;
            q2p     <= '0;
            bit_idx <= 4'd15;
            state   <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          // Square-root style search: q^2*P is grown incrementally, with
          // acc_a = P << 2b and acc_b = qP << (b+1) kept for the current bit.
          if (trial <= rr) begin
            q     <= q | (CORR_W'(1) << bit_idx);
            q2p   <= trial;
            acc_b <= (acc_b >> 1) + acc_a;
          end else begin
            acc_b <= acc_b >> 1;
          end
          acc_a   <= acc_a >> 2;
          bit_idx <= bit_idx - 1'b1;
          if (bit_idx == 4'd0) state <= S_RANK;
        end
        S_RANK: begin
          out_ch.key_guess      <= g;
          out_ch.corr_magnitude <= q;
          out_ch.overflow       <= dropped;
          out_ch.last_result    <= (g == KEY_W'(63));
          if (q > best_corr) begin
            best_corr        <= q;
            best_key         <= g;
            out_ch.best_corr <= q;
            out_ch.best_key  <= g;
          end else begin
            out_ch.best_corr <= best_corr;
            out_ch.best_key  <= best_key;
          end
          out_ch.valid <= 1'b1;
          state        <= S_EMIT;
        end
        S_EMIT: begin
          if (out_acc) begin
            out_ch.valid <= 1'b0;
            if (g == KEY_W'(63)) begin
              count   <= '0;
              sum     <= '0;
              sq      <= '0;
              dropped <= 1'b0;
              state   <= S_IDLE;
            end else begin
              g     <= g + 1'b1;
              idx   <= '0;
              sh    <= '0;
              sh2   <= '0;
              sxh   <= '0;
              state <= S_SWEEP;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // Loading and result delivery never overlap.
  a_no_load_while_result: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid) else $error("trace accepted during ranking");

  // The shared multiplier is never restarted while it is running.
  a_mul_start_idle: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy) else $error("multiplier restarted while busy");

  // The closing result is always the one for the top guess.
  a_last_is_top_guess: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.last_result) |-> (out_ch.key_guess == KEY_W'(63)))
    else $error("last result on wrong guess");

  // The running best is never below the current guess's score.
  a_best_dominates: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.best_corr >= out_ch.corr_magnitude))
    else $error("best correlation below current");

  // Delivering the closing result starts a fresh run.
  a_run_cleared: assert property (@(posedge clk) disable iff (rst)
    (out_acc && out_ch.last_result) |=> (count == '0 && !dropped))
    else $error("run state not cleared after ranking");
`endif

endmodule
